### hw/rtl/beacon_ssid_extractor_macros.svh
// assertion helpers used by the checker file
`ifndef BEACON_SSID_EXTRACTOR_MACROS_SVH
`define BEACON_SSID_EXTRACTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("beacon_ssid_extractor check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("beacon_ssid_extractor check failed");

`endif

### hw/rtl/bse_pkg.sv
package bse_pkg;

  localparam int MAX_SSID_BYTES = 32;
  localparam int FRAME_MAX   = 4095;
  localparam int STORE_DEPTH = 32;
  localparam int IE_START    = 24 + 12;
  localparam int BSSID_FIRST = 16;
  localparam int BSSID_LAST  = 21;
  localparam int SSID_LIMIT  = (MAX_SSID_BYTES < STORE_DEPTH) ? MAX_SSID_BYTES : STORE_DEPTH;

  localparam int POS_W   = 12;
  localparam int IDX_W   = 5;
  localparam int LEN_W   = 6;
  localparam int BSSID_W = 48;

  localparam logic [1:0] FC_TYPE_MGMT      = 2'b00;
  localparam logic [3:0] FC_SUB_BEACON     = 4'h8;
  localparam logic [3:0] FC_SUB_PROBE_RESP = 4'h5;
  localparam logic [7:0] EID_SSID          = 8'h00;

  typedef enum logic [1:0] {
    ST_SSID       = 2'd0,
    ST_NOT_BEACON = 2'd1,
    ST_SHORT      = 2'd2,
    ST_NO_SSID    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  function automatic logic fc_wanted(input logic [7:0] fc);
    fc_wanted = (fc[3:2] == FC_TYPE_MGMT) &&
                ((fc[7:4] == FC_SUB_BEACON) || (fc[7:4] == FC_SUB_PROBE_RESP));
  endfunction

  function automatic logic ssid_len_ok(input logic [7:0] len);
    ssid_len_ok = (len != 8'd0) && ({24'd0, len} <= 32'(SSID_LIMIT));
  endfunction

endpackage

### hw/rtl/beacon_ssid_extractor.sv
// channel  direction  ports                                         handshake
// in       input      in_frame_byte, in_last_byte                   in_valid / in_ready
// out      output     out_status, out_bssid, out_ssid_length,       out_valid / out_ready
//                     out_ssid_index, out_ssid_byte, out_run_last
//
// one frame byte per cycle; the walk state updates in the cycle the byte is taken
// an ssid run leaves one result per cycle from the result register while out_ready is
// high; input is held off until the last byte of the run is loaded, output stalls included
// any last byte is held off while the result register is full and not being drained;
// other bytes pass unless an ssid run is going out
// rst_n is synchronous, active low; the ssid store has no reset
module beacon_ssid_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [47:0] out_bssid,
  output logic [5:0]  out_ssid_length,
  output logic [4:0]  out_ssid_index,
  output logic [7:0]  out_ssid_byte,
  output logic        out_run_last
);

  localparam int PW = bse_pkg::POS_W;
  localparam int IW = bse_pkg::IDX_W;
  localparam int LW = bse_pkg::LEN_W;
  localparam int BW = bse_pkg::BSSID_W;

  // frame walk state
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [7:0]        fc_r, fc_nxt;
  bse_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]        eid_r, eid_nxt;
  logic [7:0]        erem_r, erem_nxt;
  logic [7:0]        etot_r, etot_nxt;
  logic [BW-1:0]     bssid_r, bssid_nxt;
  logic              done_r, done_nxt;
  // bssid including this byte, before the frame-end clear
  logic [BW-1:0]     bssid_seen;

  // ssid store, written during the element body
  logic [7:0]        ssid_store_r [bse_pkg::STORE_DEPTH];
  logic              store_we;
  logic [IW-1:0]     store_addr;

  // run emitter
  logic              run_active_r, run_active_nxt;
  logic [IW-1:0]     run_idx_r, run_idx_nxt;
  logic [LW-1:0]     run_len_r, run_len_nxt;
  logic [BW-1:0]     run_bssid_r, run_bssid_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [BW-1:0]     out_bssid_r, out_bssid_nxt;
  logic [LW-1:0]     out_len_r, out_len_nxt;
  logic [IW-1:0]     out_idx_r, out_idx_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              run_load;
  logic              run_final;
  logic              run_start;
  logic              status_emit;
  bse_pkg::status_t  status_code;
  logic [7:0]        body_idx;
  logic              body_cap;
  logic [7:0]        erem_dec;

  // a last byte may need the result slot; any other byte never does
  assign in_ready = !run_active_r && (!in_last_byte || !out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign run_load  = run_active_r && (!out_valid_r || out_ready);
  assign run_final = (({1'b0, run_idx_r}) + LW'(1)) == run_len_r;

  assign body_idx = etot_r - erem_r;
  assign body_cap = (eid_r == bse_pkg::EID_SSID) && bse_pkg::ssid_len_ok(etot_r);
  assign erem_dec = erem_r - 8'd1;

  always_comb begin
    pos_nxt        = pos_r;
    fc_nxt         = fc_r;
    phase_nxt      = phase_r;
    eid_nxt        = eid_r;
    erem_nxt       = erem_r;
    etot_nxt       = etot_r;
    bssid_nxt      = bssid_r;
    bssid_seen     = bssid_r;
    done_nxt       = done_r;
    store_we       = 1'b0;
    store_addr     = body_idx[IW-1:0];
    run_start      = 1'b0;
    status_emit    = 1'b0;
    status_code    = bse_pkg::ST_NOT_BEACON;
    run_bssid_nxt  = run_bssid_r;

    if (in_fire) begin
      if (!done_r) begin
        if (pos_r == '0) begin
          fc_nxt = in_frame_byte;
        end
        // bssid bytes shift in from the low end
        if ((pos_r >= PW'(bse_pkg::BSSID_FIRST)) && (pos_r <= PW'(bse_pkg::BSSID_LAST))) begin
          bssid_seen = {bssid_r[BW-9:0], in_frame_byte};
          bssid_nxt  = bssid_seen;
        end
        // information element walk
        if ((pos_r >= PW'(bse_pkg::IE_START)) && bse_pkg::fc_wanted(fc_r)) begin
          case (phase_r)
            bse_pkg::PH_ID: begin
              eid_nxt   = in_frame_byte;
              phase_nxt = bse_pkg::PH_LEN;
            end
            bse_pkg::PH_LEN: begin
              etot_nxt  = in_frame_byte;
              erem_nxt  = in_frame_byte;
              phase_nxt = (in_frame_byte == 8'd0) ? bse_pkg::PH_ID : bse_pkg::PH_BODY;
            end
            bse_pkg::PH_BODY: begin
              store_we = body_cap;
              erem_nxt = erem_dec;
              if (erem_dec == 8'd0) begin
                phase_nxt = bse_pkg::PH_ID;
                if (body_cap) begin
                  // complete ssid element: hand it to the run emitter
                  run_start     = 1'b1;
                  run_bssid_nxt = bssid_r;
                  done_nxt      = 1'b1;
                  phase_nxt     = bse_pkg::PH_STOP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      if (in_last_byte) begin
        if (!done_r && !run_start) begin
          status_emit = 1'b1;
          if ((pos_r == '0) || !bse_pkg::fc_wanted(fc_r)) begin
            status_code = bse_pkg::ST_NOT_BEACON;
          end else if (pos_r < PW'(bse_pkg::IE_START - 1)) begin
            status_code = bse_pkg::ST_SHORT;
          end else begin
            status_code = bse_pkg::ST_NO_SSID;
          end
        end
        // frame end: back to the start of the next frame
        pos_nxt   = '0;
        fc_nxt    = 8'd0;
        phase_nxt = bse_pkg::PH_ID;
        eid_nxt   = 8'd0;
        erem_nxt  = 8'd0;
        etot_nxt  = 8'd0;
        bssid_nxt = '0;
        done_nxt  = 1'b0;
      end else if (pos_r < PW'(bse_pkg::FRAME_MAX)) begin
        // position saturates on oversize frames
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  // run emitter and result register
  always_comb begin
    run_active_nxt = run_active_r;
    run_idx_nxt    = run_idx_r;
    run_len_nxt    = run_len_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_bssid_nxt  = out_bssid_r;
    out_len_nxt    = out_len_r;
    out_idx_nxt    = out_idx_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;

    if (run_load) begin
      // the byte itself is read from the store in the clocked block
      out_valid_nxt  = 1'b1;
      out_status_nxt = bse_pkg::ST_SSID;
      out_bssid_nxt  = run_bssid_r;
      out_len_nxt    = run_len_r;
      out_idx_nxt    = run_idx_r;
      out_last_nxt   = run_final;
      run_idx_nxt    = run_idx_r + IW'(1);
      if (run_final) begin
        run_active_nxt = 1'b0;
      end
    end

    if (run_start) begin
      run_active_nxt = 1'b1;
      run_idx_nxt    = '0;
      run_len_nxt    = etot_r[LW-1:0];
    end

    if (status_emit) begin
      // status item carries the bssid as updated by this byte
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_code;
      out_bssid_nxt  = bssid_seen;
      out_len_nxt    = '0;
      out_idx_nxt    = '0;
      out_byte_nxt   = 8'd0;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      fc_r         <= 8'd0;
      phase_r      <= bse_pkg::PH_ID;
      eid_r        <= 8'd0;
      erem_r       <= 8'd0;
      etot_r       <= 8'd0;
      bssid_r      <= '0;
      done_r       <= 1'b0;
      run_active_r <= 1'b0;
      run_idx_r    <= '0;
      run_len_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      fc_r         <= fc_nxt;
      phase_r      <= phase_nxt;
      eid_r        <= eid_nxt;
      erem_r       <= erem_nxt;
      etot_r       <= etot_nxt;
      bssid_r      <= bssid_nxt;
      done_r       <= done_nxt;
      run_active_r <= run_active_nxt;
      run_idx_r    <= run_idx_nxt;
      run_len_r    <= run_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    run_bssid_r  <= run_bssid_nxt;
    out_status_r <= out_status_nxt;
    out_bssid_r  <= out_bssid_nxt;
    out_len_r    <= out_len_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
    // a run load never meets a status item: input is held off during a run
    if (run_load) begin
      out_byte_r <= ssid_store_r[run_idx_r];
    end else begin
      out_byte_r <= out_byte_nxt;
    end
    if (store_we) begin
      ssid_store_r[store_addr] <= in_frame_byte;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_bssid       = out_bssid_r;
  assign out_ssid_length = out_len_r;
  assign out_ssid_index  = out_idx_r;
  assign out_ssid_byte   = out_byte_r;
  assign out_run_last    = out_last_r;

endmodule

### hw/rtl/bse_checker.sv
`include "beacon_ssid_extractor_macros.svh"

module bse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [47:0] out_bssid,
  input logic [5:0]  out_ssid_length,
  input logic [4:0]  out_ssid_index,
  input logic [7:0]  out_ssid_byte,
  input logic        out_run_last
);

  logic [69:0] out_payload;
  logic        ssid_item;
  logic        ssid_mid;
  logic        status_item;
  logic        status_empty;
  logic        idx_ok;

  assign out_payload  = {out_status, out_bssid, out_ssid_length, out_ssid_index,
                         out_ssid_byte, out_run_last};
  assign ssid_item    = out_valid && (out_status == bse_pkg::ST_SSID);
  assign ssid_mid     = ssid_item && !out_run_last;
  assign status_item  = out_valid && (out_status != bse_pkg::ST_SSID);
  assign status_empty = out_run_last && (out_ssid_length == 6'd0) &&
                        (out_ssid_index == 5'd0) && (out_ssid_byte == 8'd0);
  assign idx_ok       = (out_ssid_length != 6'd0) &&
                        (out_ssid_length <= 6'(bse_pkg::SSID_LIMIT)) &&
                        ({1'b0, out_ssid_index} < out_ssid_length);

  // stalled result holds
  `BSE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // a status item is always alone and empty
  `BSE_ASSERT_IMP(a_status_alone, status_item, status_empty)

  // ssid byte index stays within the run length
  `BSE_ASSERT_IMP(a_idx_range, ssid_item, idx_ok)

  // a run continues with the next index right after a taken byte
  `BSE_ASSERT_NXT(a_run_step, ssid_mid && out_ready, out_valid && (out_ssid_index == $past(out_ssid_index) + 5'd1))

  // no frame byte is taken while a run is still going out
  `BSE_ASSERT_IMP(a_run_holds_input, ssid_mid, !(in_valid && in_ready))

endmodule

bind beacon_ssid_extractor bse_checker u_bse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_bssid       (out_bssid),
  .out_ssid_length (out_ssid_length),
  .out_ssid_index  (out_ssid_index),
  .out_ssid_byte   (out_ssid_byte),
  .out_run_last    (out_run_last)
);

### tb/ssid_check_pkg.sv
package ssid_check_pkg;
  import bse_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [47:0] bssid;
    logic [5:0]  ssid_len;
    logic [4:0]  ssid_idx;
    logic [7:0]  ssid_byte;
    logic        run_last;
  } ssid_result_t;

  // management type with beacon or probe response subtype
  function automatic bit mgmt_wanted(input logic [7:0] fc);
    return (fc[3:2] == FC_TYPE_MGMT) &&
           ((fc[7:4] == FC_SUB_BEACON) || (fc[7:4] == FC_SUB_PROBE_RESP));
  endfunction

  class ssid_scoreboard;
    ssid_result_t     expected_q[$];
    int               errors;
    int               checked;
    int               runs_by_status[4];

    // shadow of the parser state
    logic [POS_W-1:0] pos;
    logic [7:0]       fc_low;
    phase_t           phase;
    logic [7:0]       elem_id;
    logic [7:0]       elem_left;
    logic [7:0]       elem_len;
    logic [7:0]       ssid_mem[STORE_DEPTH];
    logic [47:0]      bssid;
    bit               ssid_sent;

    function new();
      errors  = 0;
      checked = 0;
      foreach (runs_by_status[i]) runs_by_status[i] = 0;
      foreach (ssid_mem[i]) ssid_mem[i] = 8'h00;
      clear_frame();
    endfunction

    function void clear_frame();
      pos       = '0;
      fc_low    = 8'h00;
      phase     = PH_ID;
      elem_id   = 8'h00;
      elem_left = 8'h00;
      elem_len  = 8'h00;
      bssid     = '0;
      ssid_sent = 1'b0;
    endfunction

    function void add_result(input status_t st, input logic [5:0] len,
                             input logic [4:0] idx, input logic [7:0] data,
                             input logic last);
      ssid_result_t r;
      r.status    = st;
      r.bssid     = bssid;
      r.ssid_len  = len;
      r.ssid_idx  = idx;
      r.ssid_byte = data;
      r.run_last  = last;
      expected_q.push_back(r);
    endfunction

    // one accepted frame byte
    function void note_byte(input logic [7:0] b, input logic last);
      logic [POS_W-1:0] p;
      logic [7:0]       idx;
      bit               keep;
      status_t          st;
      p = pos;
      if (!ssid_sent) begin
        if (p == 0) fc_low = b;
        if (p >= BSSID_FIRST && p <= BSSID_LAST) bssid = {bssid[39:0], b};
        if (p >= IE_START && mgmt_wanted(fc_low)) begin
          case (phase)
            PH_ID: begin
              elem_id = b;
              phase   = PH_LEN;
            end
            PH_LEN: begin
              elem_len  = b;
              elem_left = b;
              if (b == 8'd0) phase = PH_ID;
              else phase = PH_BODY;
            end
            PH_BODY: begin
              idx  = elem_len - elem_left;
              keep = (elem_id == EID_SSID) && (elem_len != 8'd0) && (elem_len <= SSID_LIMIT);
              if (keep) ssid_mem[idx[4:0]] = b;
              elem_left = elem_left - 8'd1;
              if (elem_left == 8'd0) begin
                phase = PH_ID;
                if (keep) begin
                  for (int k = 0; k < elem_len; k++)
                    add_result(ST_SSID, 6'(elem_len), 5'(k), ssid_mem[k], (k + 1) == elem_len);
                  ssid_sent = 1'b1;
                  phase     = PH_STOP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      if (last) begin
        if (!ssid_sent) begin
          if (p == 0 || !mgmt_wanted(fc_low)) st = ST_NOT_BEACON;
          else if (p < IE_START - 1) st = ST_SHORT;
          else st = ST_NO_SSID;
          add_result(st, 6'd0, 5'd0, 8'd0, 1'b1);
        end
        clear_frame();
      end else if (pos < FRAME_MAX) begin
        pos = pos + 1'b1;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("mismatch at result %0d: %0s", checked, msg);
    endtask

    task check_result(input ssid_result_t got);
      ssid_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, status %0d index %0d byte %02h",
                         got.status, got.ssid_idx, got.ssid_byte));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status != want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.bssid != want.bssid)
        report($sformatf("bssid %012h, want %012h", got.bssid, want.bssid));
      if (got.ssid_len != want.ssid_len)
        report($sformatf("ssid_length %0d, want %0d", got.ssid_len, want.ssid_len));
      if (got.ssid_idx != want.ssid_idx)
        report($sformatf("ssid_index %0d, want %0d", got.ssid_idx, want.ssid_idx));
      if (got.ssid_byte != want.ssid_byte)
        report($sformatf("ssid_byte %02h, want %02h", got.ssid_byte, want.ssid_byte));
      if (got.run_last != want.run_last)
        report($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
      if (want.run_last) runs_by_status[int'(want.status)]++;
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected results never arrived", expected_q.size()));
    endtask
  endclass

endpackage

### tb/tb_beacon_ssid_extractor.sv
module tb_beacon_ssid_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;
  import ssid_check_pkg::*;

  // cycles with no item moving on either side before the run is called hung
  localparam int IDLE_LIMIT = 2000;
  // settle time after the last expected result
  localparam int TAIL_CYCLES = 40;
  // frame byte budget for the whole run; the last frame may overshoot it
  localparam int ITEMS_TARGET = 210;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_frame_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [47:0] out_bssid;
  logic [5:0]  out_ssid_length;
  logic [4:0]  out_ssid_index;
  logic [7:0]  out_ssid_byte;
  logic        out_run_last;

  ssid_scoreboard sb = new();

  // bytes of the frame being built, sent front to back
  logic [7:0] frame_q[$];
  int         burst_left = 0;
  int         frames_sent = 0;
  int         bytes_sent = 0;
  int         idle_cycles = 0;

  // receiver stall pattern, refreshed each time pat_pos wraps to zero
  logic [15:0] stall_pat = 16'hffff;
  logic [3:0]  pat_pos = 4'd0;

  beacon_ssid_extractor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frame_byte   (in_frame_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_bssid       (out_bssid),
    .out_ssid_length (out_ssid_length),
    .out_ssid_index  (out_ssid_index),
    .out_ssid_byte   (out_ssid_byte),
    .out_run_last    (out_run_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: check what is taken at this edge, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_status, out_bssid, out_ssid_length, out_ssid_index,
                       out_ssid_byte, out_run_last});
    if (pat_pos == 4'd0) begin
      // a quarter of the windows never stall
      if ($urandom_range(0, 3) == 0) stall_pat = 16'hffff;
      else stall_pat = 16'($urandom);
    end
    out_ready <= stall_pat[pat_pos];
    pat_pos = pat_pos + 4'd1;
  end

  // hang detection: nothing accepted for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // one byte, with bursts and gaps; valid is only dropped when a gap follows
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // occasional long stretch with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    in_valid      <= 1'b1;
    in_frame_byte <= b;
    in_last_byte  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, last);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
    frames_sent++;
  endtask

  // frame control byte plus random header up to the element area
  task automatic add_header(input logic [7:0] fc);
    frame_q.push_back(fc);
    repeat (IE_START - 1) frame_q.push_back(8'($urandom));
  endtask

  task automatic set_bssid(input logic [7:0] fill);
    for (int i = BSSID_FIRST; i <= BSSID_LAST; i++) frame_q[i] = fill;
  endtask

  // fill below zero means random body bytes
  task automatic add_element(input logic [7:0] id, input int len, input int fill);
    frame_q.push_back(id);
    frame_q.push_back(8'(len));
    repeat (len) frame_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  task automatic trim_to(input int n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  function automatic logic [7:0] wanted_fc();
    logic [3:0] sub;
    sub = $urandom_range(0, 1) ? FC_SUB_BEACON : FC_SUB_PROBE_RESP;
    return {sub, FC_TYPE_MGMT, 2'($urandom)};
  endfunction

  task automatic random_frame();
    int         kind;
    int         len;
    logic [7:0] id;
    logic [7:0] fc;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      // well-formed beacon or probe response with a few elements
      add_header(wanted_fc());
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 9) < 4) begin
          id  = EID_SSID;
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                            : $urandom_range(1, SSID_LIMIT);
        end else begin
          id  = 8'($urandom_range(1, 255));
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40)
                                             : $urandom_range(0, 12);
        end
        add_element(id, len, -1);
      end
      repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
      // sometimes cut inside the element area
      if ($urandom_range(0, 5) == 0) trim_to($urandom_range(IE_START + 1, frame_q.size()));
    end else if (kind < 75) begin
      // some other frame type
      do fc = 8'($urandom); while (mgmt_wanted(fc));
      frame_q.push_back(fc);
      repeat ($urandom_range(0, 70)) frame_q.push_back(8'($urandom));
    end else if (kind < 90) begin
      // beacon or probe response that ends before or at the element area
      add_header(wanted_fc());
      trim_to($urandom_range(1, IE_START));
    end else begin
      // noise: any control byte, random tail
      add_header(8'($urandom));
      repeat ($urandom_range(0, 40)) frame_q.push_back(8'($urandom));
    end
    send_frame();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte frames: not a beacon regardless of content
    frame_q.push_back(8'h80);
    send_frame();
    frame_q.push_back(8'h00);
    send_frame();

    // beacons ending early: inside the bssid, and on the last header byte
    add_header(8'h80);
    trim_to(19);
    send_frame();
    add_header(8'h80);
    trim_to(IE_START);
    send_frame();

    // probe response with bssid all ones: empty element, empty ssid, largest ssid
    // of all ones, then a second ssid that must be ignored
    add_header(8'h53);
    set_bssid(8'hff);
    add_element(8'd1, 0, -1);
    add_element(EID_SSID, 0, -1);
    add_element(EID_SSID, SSID_LIMIT, 255);
    add_element(EID_SSID, 1, 0);
    send_frame();

    // ssid cut off in its body
    add_header(8'h80);
    add_element(EID_SSID, 10, -1);
    trim_to(frame_q.size() - 6);
    send_frame();

    // random frames up to the byte budget
    while (bytes_sent < ITEMS_TARGET) random_frame();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_drained();

    $display("sent %0d frames (%0d bytes), checked %0d results", frames_sent, bytes_sent,
             sb.checked);
    $display("frame outcomes: ssid %0d, not beacon %0d, too short %0d, no ssid %0d",
             sb.runs_by_status[ST_SSID], sb.runs_by_status[ST_NOT_BEACON],
             sb.runs_by_status[ST_SHORT], sb.runs_by_status[ST_NO_SSID]);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
